FILE: design/rke_pkg.sv
// ---------------------------------------------------------------------------
// rke_pkg: shared types and constants for the rotary knob event generator
// Event codes, register indexes, reset values and the structs passed
// between the top level, the switch tracker and the output buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package rke_pkg;

   // event codes carried in the result transaction
   typedef enum logic [2:0] {
      KIND_NONE      = 3'd0,
      KIND_ROTATE    = 3'd1,
      KIND_PRESS     = 3'd2,
      KIND_LONG      = 3'd3,
      KIND_VERY_LONG = 3'd4
   } kind_type;

   // register indexes on the csr port
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EDGE_DEBOUNCE_US     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SWITCH_POLL_MS       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SWITCH_DEBOUNCE_MS   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_HOLD_MS         = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERY_LONG_HOLD_MS    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SWITCH_PRESENT       = 3'd5;

   // register reset values
   localparam logic [15:0] RST_EDGE_DEBOUNCE_US   = 16'd1200;
   localparam logic [15:0] RST_SWITCH_POLL_MS     = 16'd5;
   localparam logic [15:0] RST_SWITCH_DEBOUNCE_MS = 16'd30;
   localparam logic [15:0] RST_LONG_HOLD_MS       = 16'd1000;
   localparam logic [15:0] RST_VERY_LONG_HOLD_MS  = 16'd5000;
   localparam logic        RST_SWITCH_PRESENT     = 1'b1;

   // rotation delta clamp limits
   localparam logic signed [7:0] DELTA_MAX      = 8'sd127;
   localparam logic signed [7:0] DELTA_MIN      = -8'sd127;
   localparam logic [31:0]       DELTA_POS_WORD = 32'd127;
   localparam logic [31:0]       DELTA_NEG_WORD = 32'hFFFF_FF81;

   // switch tracker settings
   typedef struct packed {
      logic [15:0] poll_interval_ms;
      logic [15:0] debounce_ms;
      logic [15:0] long_hold_ms;
      logic [15:0] very_long_hold_ms;
      logic        present;
   } sw_cfg_type;

   // switch tracker event
   typedef struct packed {
      logic     fire;
      kind_type kind;
   } sw_event_type;

   // one result transaction
   typedef struct packed {
      kind_type          kind;
      logic signed [7:0]  delta;
      logic signed [31:0] position;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/rke_switch.sv
// ---------------------------------------------------------------------------
// rke_switch: push switch sampler, debouncer and press classifier
// Samples the active-low switch at a limited rate on each poll, debounces
// level changes and reports press, long press and very long press events.
// ---------------------------------------------------------------------------
`default_nettype none

module rke_switch (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rke_pkg::sw_cfg_type cfg,
   input  wire logic                poll,
   input  wire logic [31:0]         time_ms,
   input  wire logic                switch_level,
   output rke_pkg::sw_event_type    event_out
);

   logic        held_ff, held_in;
   logic        long_done_ff, long_done_in;
   logic        very_done_ff, very_done_in;
   logic [31:0] last_sample_ff, last_sample_in;
   logic [31:0] last_change_ff, last_change_in;
   logic [31:0] press_start_ff, press_start_in;

   logic        sample_due;
   logic        down;
   logic        change;
   logic        new_press;
   logic        held_now;
   logic        long_now;
   logic        very_now;
   logic [31:0] elapsed;
   logic        fire_long;
   logic        fire_very;
   logic        fire_press;

   // sample rate limit and debounce of the switch level
   always_comb begin
      sample_due = (time_ms - last_sample_ff) >= {16'd0, cfg.poll_interval_ms};
      down       = ~switch_level;
      change     = sample_due && cfg.present && (down != held_ff)
                   && ((time_ms - last_change_ff) >= {16'd0, cfg.debounce_ms});
      new_press  = change && down;
      held_now   = change ? down : held_ff;
      long_now   = new_press ? 1'b0 : long_done_ff;
      very_now   = new_press ? 1'b0 : very_done_ff;
      elapsed    = new_press ? 32'd0 : (time_ms - press_start_ff);
   end

   // press classification, long press first
   always_comb begin
      fire_long  = held_now && !long_now && (elapsed >= {16'd0, cfg.long_hold_ms});
      fire_very  = !fire_long && held_now && long_now && !very_now
                   && (elapsed >= {16'd0, cfg.very_long_hold_ms});
      fire_press = !fire_long && !fire_very && held_ff && !held_now && !long_now;

      event_out.fire = poll && (fire_long || fire_very || fire_press);
      priority if (fire_long) begin
         event_out.kind = rke_pkg::KIND_LONG;
      end else if (fire_very) begin
         event_out.kind = rke_pkg::KIND_VERY_LONG;
      end else if (fire_press) begin
         event_out.kind = rke_pkg::KIND_PRESS;
      end else begin
         event_out.kind = rke_pkg::KIND_NONE;
      end
   end

   // next state, only on a poll that reaches the switch
   always_comb begin
      held_in        = held_ff;
      long_done_in   = long_done_ff;
      very_done_in   = very_done_ff;
      last_sample_in = last_sample_ff;
      last_change_in = last_change_ff;
      press_start_in = press_start_ff;
      if (poll) begin
         if (sample_due) begin
            last_sample_in = time_ms;
         end
         if (change) begin
            last_change_in = time_ms;
            held_in        = down;
         end
         if (new_press) begin
            press_start_in = time_ms;
         end
         long_done_in = long_now || fire_long;
         very_done_in = very_now || fire_very;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff        <= 1'b0;
         long_done_ff   <= 1'b0;
         very_done_ff   <= 1'b0;
         last_sample_ff <= 32'd0;
         last_change_ff <= 32'd0;
         press_start_ff <= 32'd0;
      end else begin
         held_ff        <= held_in;
         long_done_ff   <= long_done_in;
         very_done_ff   <= very_done_in;
         last_sample_ff <= last_sample_in;
         last_change_ff <= last_change_in;
         press_start_ff <= press_start_in;
      end
   end

   // very long press is only marked after long press in the same hold
   assert property (@(posedge clock) disable iff (reset)
      very_done_ff |-> long_done_ff)
      else $error("very long press marked without long press");

   // a new press clears both press marks
   assert property (@(posedge clock) disable iff (reset)
      (poll && new_press && !fire_long) |=> (held_ff && !long_done_ff && !very_done_ff))
      else $error("press marks not cleared on a new press");

   // a short press is reported only on a release
   assert property (@(posedge clock) disable iff (reset)
      (event_out.fire && event_out.kind == rke_pkg::KIND_PRESS) |=> !held_ff)
      else $error("short press reported while still held");

endmodule

`default_nettype wire

FILE: design/rke_out_buffer.sv
// ---------------------------------------------------------------------------
// rke_out_buffer: two-entry result buffer
// Holds the result register and a skid entry so that the input side
// keeps accepting while the consumer stalls for one transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module rke_out_buffer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire rke_pkg::rsp_type in_data,
   output logic                  in_space,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output rke_pkg::rsp_type      out_data
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   rke_pkg::rsp_type main_ff, main_in;
   rke_pkg::rsp_type skid_ff, skid_in;

   // refill the result register from the skid entry first
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = in_valid;
         end
      end else if (in_valid) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_space  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // the skid entry is only used behind a full result register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds data while result register is empty");

   // no new transaction arrives while the buffer is full
   assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_valid_ff)
      else $error("result written into a full buffer");

   // a stalled result with a new one behind it fills the skid entry
   assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !out_ready && in_valid) |=> skid_valid_ff)
      else $error("result dropped while consumer stalled");

endmodule

`default_nettype wire

FILE: design/rotary_knob_event_generator.sv
// ---------------------------------------------------------------------------
// rotary_knob_event_generator: quadrature knob with push switch events
// Tracks encoder position from pin samples and reports rotation and
// press events on polls.
// ---------------------------------------------------------------------------
// One request transaction is taken every clock while req_ready is high. A
// pin sample or poll is handled in the cycle it is accepted, and its result,
// if any, is registered in the result register of the output buffer, or in
// its skid entry while the consumer stalls, before it shows on the rsp port.
// A two-entry result buffer lets requests keep flowing while the consumer
// stalls; req_ready drops only when both entries are full. Pin samples never
// produce a result, and a poll with nothing to report produces none.
// Registers are written on csr_write_enable with csr_index selecting the
// register; write them only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module rotary_knob_event_generator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_operation,
   input  wire logic                                 req_level_a,
   input  wire logic                                 req_level_b,
   input  wire logic                                 req_switch_level,
   input  wire logic [31:0]                          req_time_us,
   input  wire logic [31:0]                          req_time_ms,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [2:0]                                rsp_event_kind,
   output logic signed [7:0]                         rsp_rotate_delta,
   output logic signed [31:0]                        rsp_current_position,
   input  wire logic                                 csr_write_enable,
   input  wire logic [rke_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [rke_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   // configuration registers
   logic [15:0]         edge_debounce_ff;
   rke_pkg::sw_cfg_type sw_cfg_ff;

   // encoder state
   logic        prev_a_ff, prev_a_in;
   logic [31:0] last_edge_ff, last_edge_in;
   logic [31:0] position_ff, position_in;
   logic [31:0] reported_ff, reported_in;

   logic                  accept;
   logic                  is_poll;
   logic                  pending;
   logic [31:0]           backlog;
   logic signed [7:0]     delta;
   logic                  sw_poll;
   rke_pkg::sw_event_type sw_event;
   logic                  result_valid;
   rke_pkg::rsp_type      result;
   rke_pkg::rsp_type      rsp_data;
   logic                  buffer_space;

   assign accept  = req_valid && req_ready;
   assign is_poll = req_operation;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_debounce_ff            <= rke_pkg::RST_EDGE_DEBOUNCE_US;
         sw_cfg_ff.poll_interval_ms  <= rke_pkg::RST_SWITCH_POLL_MS;
         sw_cfg_ff.debounce_ms       <= rke_pkg::RST_SWITCH_DEBOUNCE_MS;
         sw_cfg_ff.long_hold_ms      <= rke_pkg::RST_LONG_HOLD_MS;
         sw_cfg_ff.very_long_hold_ms <= rke_pkg::RST_VERY_LONG_HOLD_MS;
         sw_cfg_ff.present           <= rke_pkg::RST_SWITCH_PRESENT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rke_pkg::CSR_EDGE_DEBOUNCE_US:   edge_debounce_ff            <= csr_write_data;
            rke_pkg::CSR_SWITCH_POLL_MS:     sw_cfg_ff.poll_interval_ms  <= csr_write_data;
            rke_pkg::CSR_SWITCH_DEBOUNCE_MS: sw_cfg_ff.debounce_ms       <= csr_write_data;
            rke_pkg::CSR_LONG_HOLD_MS:       sw_cfg_ff.long_hold_ms      <= csr_write_data;
            rke_pkg::CSR_VERY_LONG_HOLD_MS:  sw_cfg_ff.very_long_hold_ms <= csr_write_data;
            rke_pkg::CSR_SWITCH_PRESENT:     sw_cfg_ff.present           <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // rotation backlog clamped to the delta range
   always_comb begin
      pending = (position_ff != reported_ff);
      backlog = position_ff - reported_ff;
      if (!backlog[31]) begin
         delta = (backlog > rke_pkg::DELTA_POS_WORD) ? rke_pkg::DELTA_MAX : backlog[7:0];
      end else begin
         delta = (backlog < rke_pkg::DELTA_NEG_WORD) ? rke_pkg::DELTA_MIN : backlog[7:0];
      end
   end

   // encoder edge tracking and report bookkeeping
   always_comb begin
      prev_a_in    = prev_a_ff;
      last_edge_in = last_edge_ff;
      position_in  = position_ff;
      reported_in  = reported_ff;
      if (accept && !is_poll) begin
         prev_a_in = req_level_a;
         if ((req_level_a != prev_a_ff)
             && ((req_time_us - last_edge_ff) >= {16'd0, edge_debounce_ff})) begin
            last_edge_in = req_time_us;
            position_in  = (req_level_a != req_level_b) ? position_ff - 32'd1
                                                        : position_ff + 32'd1;
         end
      end else if (accept && pending) begin
         reported_in = reported_ff + {{24{delta[7]}}, delta};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff    <= 1'b1;
         last_edge_ff <= 32'd0;
         position_ff  <= 32'd0;
         reported_ff  <= 32'd0;
      end else begin
         prev_a_ff    <= prev_a_in;
         last_edge_ff <= last_edge_in;
         position_ff  <= position_in;
         reported_ff  <= reported_in;
      end
   end

   // switch handling runs only on polls with no rotation pending
   assign sw_poll = accept && is_poll && !pending;

   rke_switch u_switch (
      .clock        (clock),
      .reset        (reset),
      .cfg          (sw_cfg_ff),
      .poll         (sw_poll),
      .time_ms      (req_time_ms),
      .switch_level (req_switch_level),
      .event_out    (sw_event)
   );

   // result selection
   always_comb begin
      result.position = position_ff;
      if (pending) begin
         result.kind  = rke_pkg::KIND_ROTATE;
         result.delta = delta;
      end else begin
         result.kind  = sw_event.kind;
         result.delta = 8'sd0;
      end
      result_valid = accept && is_poll && (pending || sw_event.fire);
   end

   rke_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (result_valid),
      .in_data   (result),
      .in_space  (buffer_space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign req_ready            = buffer_space;
   assign rsp_event_kind       = rsp_data.kind;
   assign rsp_rotate_delta     = rsp_data.delta;
   assign rsp_current_position = rsp_data.position;

   // a pin sample never moves the reported count
   assert property (@(posedge clock) disable iff (reset)
      (accept && !is_poll) |=> (reported_ff == $past(reported_ff)))
      else $error("reported count moved on a pin sample");

   // a poll never moves the position
   assert property (@(posedge clock) disable iff (reset)
      (accept && is_poll) |=> (position_ff == $past(position_ff)))
      else $error("position moved on a poll");

   // a rotate report closes the backlog when it fits in one delta
   assert property (@(posedge clock) disable iff (reset)
      (accept && is_poll && pending && (backlog == {{24{delta[7]}}, delta}))
      |=> (reported_ff == position_ff))
      else $error("small backlog not cleared by one report");

endmodule

`default_nettype wire
